// ----- src/ple_pkg.sv -----
// Shared types and constants for the positional list engine.
package ple_pkg;

  localparam int POS_W   = 8;
  localparam int WORD_W  = 32;
  localparam int ECNT_W  = 5;

  typedef enum logic [1:0] {
    ACT_APPEND = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_REMOVE = 2'd2,
    ACT_DUMP   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_DUMP = 1'b1
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic take;        // request accepted this cycle
    logic step;        // emit one dump entry and rotate
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;    // output slot empty or being drained
    logic nonempty;    // count != 0
    logic dump_last;   // current dump entry is the final one
  } dp_stat_t;

endpackage

// ----- src/ple_if.sv -----
// Request and response channel interfaces.
interface ple_req_if;
  import ple_pkg::*;
  logic                        valid;
  logic                        ready;
  action_t                     action;
  logic [POS_W-1:0]            position;
  logic signed [WORD_W-1:0]    value;
  modport source (output valid, action, position, value, input ready);
  modport sink   (input valid, action, position, value, output ready);
endinterface

interface ple_rsp_if;
  import ple_pkg::*;
  logic                        valid;
  logic                        ready;
  status_t                     status;
  logic signed [WORD_W-1:0]    entry;
  logic [ECNT_W-1:0]           entry_count;
  logic                        last;
  modport source (output valid, status, entry, entry_count, last, input ready);
  modport sink   (input valid, status, entry, entry_count, last, output ready);
endinterface

// ----- src/positional_list_engine.sv -----
// Top level: positional list engine, controller plus datapath.
// Edits: the response is registered and appears in the cycle after the request is accepted.
// Edits sustain one request per cycle while responses drain; the entry array shifts in
// parallel. A non-empty dump emits count responses, one per cycle while responses drain,
// by rotating the array within count; no request is accepted until the final one issues.
// Reset (synchronous, active high) clears count, dump index, FSM and response valid;
// stored entries keep their contents and are read only below count.
module positional_list_engine #(
  parameter int DEPTH = 16
) (
  input  logic      clk,
  input  logic      rst,
  ple_req_if.sink   req,
  ple_rsp_if.source rsp
);
  import ple_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;
  logic     in_ready;

  assign req.ready = in_ready;

  // Controller: decides when a request is taken and paces the dump.
  ple_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req.valid),
    .req_action (req.action),
    .req_ready  (in_ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // Datapath: list storage, count and the response register.
  ple_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .req_action   (req.action),
    .req_position (req.position),
    .req_value    (req.value),
    .cmd          (cmd),
    .stat         (stat),
    .rsp          (rsp)
  );

endmodule

// ----- src/ple_ctrl.sv -----
// Controller: request acceptance and dump sequencing.
module ple_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  input  ple_pkg::action_t   req_action,
  output logic               req_ready,
  input  ple_pkg::dp_stat_t  stat,
  output ple_pkg::ctl_cmd_t  cmd
);
  import ple_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd.take && req_action == ACT_DUMP && stat.nonempty) state_next = S_DUMP;
      end
      S_DUMP: begin
        if (cmd.step && stat.dump_last) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    req_ready = 1'b0;
    cmd       = '0;
    case (state)
      S_IDLE: begin
        req_ready = stat.out_free;
        cmd.take  = stat.out_free && req_valid;
      end
      S_DUMP: begin
        cmd.step = stat.out_free;
      end
      default: ;
    endcase
  end

endmodule

// ----- src/ple_dp.sv -----
// Datapath: entry array, count, dump index and response register.
module ple_dp #(
  parameter int DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  ple_pkg::action_t              req_action,
  input  logic [ple_pkg::POS_W-1:0]     req_position,
  input  logic signed [ple_pkg::WORD_W-1:0] req_value,
  input  ple_pkg::ctl_cmd_t             cmd,
  output ple_pkg::dp_stat_t             stat,
  ple_rsp_if.source                     rsp
);
  import ple_pkg::*;

  localparam int CW   = $clog2(DEPTH + 1);
  localparam int IW   = $clog2(DEPTH);
  localparam int CMPW = CW + POS_W;
  localparam int EXW  = CW + ECNT_W;

  logic signed [WORD_W-1:0] e   [DEPTH];
  logic signed [WORD_W-1:0] prv [DEPTH];
  logic signed [WORD_W-1:0] nxt [DEPTH];
  logic [CW-1:0]            count, count_next;
  logic [IW-1:0]            k;

  logic          full, is_add, is_rem, pos_past, add_ok, rem_ok;
  logic [CW-1:0] tgt;
  logic [EXW-1:0] cnt_ext;

  // neighbor taps, fixed per element
  for (genvar g = 0; g < DEPTH; g++) begin : g_tap
    if (g == 0) begin : g_first
      assign prv[g] = '0;
    end else begin : g_rest
      assign prv[g] = e[g-1];
    end
    if (g == DEPTH - 1) begin : g_end
      assign nxt[g] = '0;
    end else begin : g_mid
      assign nxt[g] = e[g+1];
    end
  end

  assign full     = (count == CW'(DEPTH));
  assign is_add   = (req_action == ACT_APPEND) || (req_action == ACT_INSERT);
  assign is_rem   = (req_action == ACT_REMOVE);
  assign pos_past = (CMPW'(req_position) >= CMPW'(count));
  assign add_ok   = cmd.take && is_add && !full;
  assign rem_ok   = cmd.take && is_rem && stat.nonempty && !pos_past;
  assign tgt      = (req_action == ACT_APPEND || pos_past) ? count : CW'(req_position);

  always_comb begin
    count_next = count;
    if (add_ok)      count_next = count + CW'(1);
    else if (rem_ok) count_next = count - CW'(1);
  end

  assign cnt_ext = EXW'(count_next);

  assign stat.out_free  = !rsp.valid || rsp.ready;
  assign stat.nonempty  = (count != '0);
  assign stat.dump_last = (CW'(k) + CW'(1) == count);

  // entry array: parallel shift on edits, rotate within count on dump
  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      if (add_ok) begin
        if (CW'(i) == tgt) e[i] <= req_value;
        else if (CW'(i) > tgt && CW'(i) <= count) e[i] <= prv[i];
      end else if (rem_ok) begin
        if (CMPW'(i) >= CMPW'(req_position) && CW'(i + 1) < count) e[i] <= nxt[i];
      end else if (cmd.step) begin
        if (CW'(i + 1) < count) e[i] <= nxt[i];
        else if (CW'(i + 1) == count) e[i] <= e[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      k         <= '0;
      rsp.valid <= 1'b0;
    end else begin
      count <= count_next;
      if (cmd.take) k <= '0;
      else if (cmd.step) k <= k + IW'(1);

      if (cmd.take) begin
        rsp.valid <= !(req_action == ACT_DUMP && stat.nonempty);
      end else if (cmd.step) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  // response payload
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      rsp.entry       <= '0;
      rsp.last        <= 1'b1;
      rsp.entry_count <= cnt_ext[ECNT_W-1:0];
      case (req_action)
        ACT_APPEND, ACT_INSERT: rsp.status <= full ? ST_FULL : ST_OK;
        ACT_REMOVE: rsp.status <= !stat.nonempty ? ST_EMPTY : (pos_past ? ST_RANGE : ST_OK);
        ACT_DUMP:   rsp.status <= ST_EMPTY;
        default:    rsp.status <= ST_OK;
      endcase
    end else if (cmd.step) begin
      rsp.entry       <= e[0];
      rsp.last        <= stat.dump_last;
      rsp.entry_count <= cnt_ext[ECNT_W-1:0];
      rsp.status      <= ST_OK;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("count exceeds depth");

  a_take_slot: assert property (@(posedge clk) disable iff (rst)
    (cmd.take || cmd.step) |-> (!rsp.valid || rsp.ready))
    else $error("response overwritten while held");

  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(cmd.take && cmd.step))
    else $error("edit and dump step together");

  a_dump_stable: assert property (@(posedge clk) disable iff (rst)
    cmd.step |=> $stable(count))
    else $error("count changed during dump");

endmodule

// ----- tb/sv/positional_list_engine_test.sv -----
// Self-checking testbench for the positional list engine.
module positional_list_engine_test;
  import ple_pkg::*;

  localparam int LIST_DEPTH = 16;

  // One response as the engine should produce it.
  typedef struct {
    status_t                  status;
    logic signed [WORD_W-1:0] entry;
    logic [ECNT_W-1:0]        entry_count;
    logic                     last;
  } list_result_t;

  // Shadow copy of the list plus the responses still owed by the engine.
  class list_ledger;
    logic signed [WORD_W-1:0] words[LIST_DEPTH];
    int unsigned              fill;
    list_result_t             owed[$];
    int unsigned              errors;

    function void owe(status_t st, logic signed [WORD_W-1:0] word, logic lst);
      list_result_t r;
      r.status      = st;
      r.entry       = word;
      r.entry_count = fill[ECNT_W-1:0];
      r.last        = lst;
      owed.push_back(r);
    endfunction

    function int unsigned pending();
      return owed.size();
    endfunction

    // Apply one accepted request to the shadow list and queue its responses.
    function void note(action_t act, logic [POS_W-1:0] pos,
                       logic signed [WORD_W-1:0] val);
      int unsigned slot;
      case (act)
        ACT_APPEND, ACT_INSERT: begin
          if (fill >= LIST_DEPTH) begin
            owe(ST_FULL, '0, 1'b1);
          end else begin
            slot = (act == ACT_APPEND || pos >= fill) ? fill : pos;
            for (int unsigned i = fill; i > slot; i--) words[i] = words[i-1];
            words[slot] = val;
            fill++;
            owe(ST_OK, '0, 1'b1);
          end
        end
        ACT_REMOVE: begin
          if (fill == 0) begin
            owe(ST_EMPTY, '0, 1'b1);
          end else if (pos >= fill) begin
            owe(ST_RANGE, '0, 1'b1);
          end else begin
            for (int unsigned i = pos; i + 1 < fill; i++) words[i] = words[i+1];
            fill--;
            owe(ST_OK, '0, 1'b1);
          end
        end
        default: begin
          if (fill == 0) begin
            owe(ST_EMPTY, '0, 1'b1);
          end else begin
            for (int unsigned i = 0; i < fill; i++)
              owe(ST_OK, words[i], (i + 1 == fill));
          end
        end
      endcase
    endfunction

    // Compare one accepted response against the oldest owed one.
    function void check(status_t st, logic signed [WORD_W-1:0] ent,
                        logic [ECNT_W-1:0] cnt, logic lst);
      list_result_t r;
      if (owed.size() == 0) begin
        $display("%0t: unexpected response status %0d entry %0d count %0d last %0d",
                 $time, st, ent, cnt, lst);
        errors++;
        return;
      end
      r = owed.pop_front();
      if (st !== r.status) begin
        $display("%0t: status expected %0d actual %0d", $time, r.status, st);
        errors++;
      end
      if (ent !== r.entry) begin
        $display("%0t: entry expected %0d actual %0d", $time, r.entry, ent);
        errors++;
      end
      if (cnt !== r.entry_count) begin
        $display("%0t: entry_count expected %0d actual %0d", $time, r.entry_count, cnt);
        errors++;
      end
      if (lst !== r.last) begin
        $display("%0t: last expected %0d actual %0d", $time, r.last, lst);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  ple_req_if req_ch ();
  ple_rsp_if rsp_ch ();

  positional_list_engine #(.DEPTH(LIST_DEPTH)) uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  list_ledger ledger = new();

  // When set, neither side idles: back-to-back requests, ready held high.
  bit steady;
  // Idle cycles the sender inserts before its next request.
  int gap_before;

  always #5 clk = ~clk;

  // Mostly short gaps, a few long ones.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 24);
  endfunction

  // Position near the live range, so that edits land on real entries and on the
  // exact end; now and then anywhere in the 8-bit field.
  function automatic logic [POS_W-1:0] pick_pos();
    if ($urandom_range(0, 99) < 12) return POS_W'($urandom_range(0, 255));
    return POS_W'($urandom_range(0, ledger.fill));
  endfunction

  // Offer one request and hold it until the engine takes it. valid stays
  // high into the next request when no gap follows, so it is never dropped
  // and raised in the same step.
  task automatic send_request(input action_t act, input logic [POS_W-1:0] pos,
                              input logic signed [WORD_W-1:0] val);
    repeat (gap_before) @(posedge clk);
    req_ch.valid    <= 1'b1;
    req_ch.action   <= act;
    req_ch.position <= pos;
    req_ch.value    <= val;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    ledger.note(act, pos, val);
    gap_before = steady ? 0 : pick_gap();
    if (gap_before != 0) req_ch.valid <= 1'b0;
  endtask

  // Sender backs off until every owed response has come back.
  task automatic settle();
    if (gap_before == 0) req_ch.valid <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk);
    repeat ($urandom_range(1, 5)) @(posedge clk);
  endtask

  // Random request; grow phases favor append/insert so the list fills up,
  // shrink phases favor remove so it empties and hits the error paths.
  task automatic random_request(input bit grow);
    int r;
    action_t act;
    r = $urandom_range(0, 99);
    if (grow)
      act = (r < 35) ? ACT_APPEND : (r < 70) ? ACT_INSERT :
            (r < 85) ? ACT_REMOVE : ACT_DUMP;
    else
      act = (r < 10) ? ACT_APPEND : (r < 20) ? ACT_INSERT :
            (r < 80) ? ACT_REMOVE : ACT_DUMP;
    send_request(act, pick_pos(), $urandom);
  endtask

  // Response side: check every accepted response, and toggle ready with
  // runs of random length (long stalls now and then).
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        ledger.check(rsp_ch.status, rsp_ch.entry, rsp_ch.entry_count, rsp_ch.last);
      if (hold > 0) begin
        hold--;
      end else if (steady || $urandom_range(0, 2) != 0) begin
        rsp_ch.ready <= 1'b1;
        hold = $urandom_range(0, 6);
      end else begin
        rsp_ch.ready <= 1'b0;
        hold = pick_gap();
      end
    end
  end

  // Main sequence.
  initial begin
    clk             = 1'b0;
    rst             = 1'b1;
    req_ch.valid    = 1'b0;
    req_ch.action   = ACT_APPEND;
    req_ch.position = '0;
    req_ch.value    = '0;
    rsp_ch.ready    = 1'b0;
    steady          = 1'b0;
    gap_before      = 0;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty list behavior first.
    send_request(ACT_DUMP,   8'd0,   32'sd0);            // dump of empty list
    send_request(ACT_REMOVE, 8'd255, 32'sd0);            // remove from empty list
    // Extreme words, head insert, middle insert, insert past end.
    send_request(ACT_APPEND, 8'd17,  32'sh8000_0000);
    send_request(ACT_APPEND, 8'd0,   32'sh7fff_ffff);
    send_request(ACT_INSERT, 8'd0,   -32'sd1);
    send_request(ACT_INSERT, 8'd1,   32'sd0);
    send_request(ACT_INSERT, 8'd255, 32'sh5555_5555);
    send_request(ACT_INSERT, 8'd5,   32'shaaaa_aaaa);    // position equal to count
    send_request(ACT_DUMP,   8'd255, 32'sh1234_5678);
    // Remove at or past count is out of range.
    send_request(ACT_REMOVE, 8'd255, 32'sd0);
    send_request(ACT_REMOVE, 8'd6,   32'sd0);
    // Fill up, then append and insert on a full list.
    repeat (LIST_DEPTH - 6) send_request(ACT_APPEND, pick_pos(), $urandom);
    send_request(ACT_APPEND, 8'd0,   32'sd99);
    send_request(ACT_INSERT, 8'd0,   32'sd98);
    send_request(ACT_DUMP,   8'd0,   32'sd0);            // sixteen-entry dump
    // Remove head, tail and a middle entry.
    send_request(ACT_REMOVE, 8'd0,   32'sd0);
    send_request(ACT_REMOVE, 8'd14,  32'sd0);
    send_request(ACT_REMOVE, 8'd7,   32'sd0);
    settle();

    // Random phases, alternating grow and shrink; two of them run with no
    // idling on either side. The sender drains fully between phases.
    for (int phase = 0; phase < 6; phase++) begin
      steady = (phase == 2 || phase == 5);
      for (int n = 0; n < 56; n++) random_request(phase % 2 == 0);
      steady = 1'b0;
      settle();
    end

    // Sweep the list to empty and dump it once more.
    while (ledger.fill != 0) send_request(ACT_REMOVE, 8'd0, $urandom);
    send_request(ACT_DUMP, 8'd3, $urandom);

    settle();
    repeat (20) @(posedge clk);
    if (ledger.errors == 0 && ledger.pending() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  // Watchdog.
  initial begin
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
